// ===== design/teq_pkg.sv =====
// Shared types, constants and helpers for the timed event queue.
// No dependencies; used by teq_rsp_reg and timed_event_queue.
`default_nettype none

package teq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int MAX_FIRES   = 16;

   localparam int TIME_W   = 32;
   localparam int PORT_TAG_W = 16;
   localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int IDX_W1   = IDX_W + 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int FIRE_W   = $clog2(MAX_FIRES + 1);

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_ABS  = 2'd1,
      FUNC_REL  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_FIRED    = 2'd2,
      KIND_NONE_DUE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0]   due;
      logic [TIME_W-1:0]   period;
      logic [TAG_BITS-1:0] tag;
   } slot_type;

   typedef struct packed {
      kind_type              kind;
      logic [PORT_TAG_W-1:0] tag;
      logic [TIME_W-1:0]     fire_time;
      logic                  last;
   } rsp_type;

   // physical slot of a logical position counted from the head
   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] pos);
      logic [IDX_W1-1:0] s;
      s = {1'b0, head} + {1'b0, pos};
      if (s >= IDX_W1'(QUEUE_DEPTH)) begin
         s = s - IDX_W1'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

   function automatic logic [TAG_BITS-1:0] tag_from_port(input logic [PORT_TAG_W-1:0] v);
      logic [TAG_BITS+PORT_TAG_W-1:0] w;
      w = {{TAG_BITS{1'b0}}, v};
      return w[TAG_BITS-1:0];
   endfunction

   function automatic logic [PORT_TAG_W-1:0] tag_to_port(input logic [TAG_BITS-1:0] v);
      logic [TAG_BITS+PORT_TAG_W-1:0] w;
      w = {{PORT_TAG_W{1'b0}}, v};
      return w[PORT_TAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/timed_event_queue.sv =====
// Timed event queue top level: sorted slot memory, sequencer, result register.
// Depends on teq_pkg and teq_rsp_reg.
`default_nettype none

//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  req     | req_valid req_stall req_func req_time_value         | in
//          | req_event_tag req_reload                           |
//  rsp     | rsp_valid rsp_stall rsp_result_kind rsp_fired_tag  | out
//          | rsp_fire_time rsp_last                             |
//
// Sequence: an accepted schedule holds req stalled while each queued event with
//   a due time at or after the new one is moved up one slot through the slot
//   memory's read and write ports, until the scan stops at an event due earlier
//   or at the head. A rejected schedule goes straight to its result, an unused
//   code gives none. A tick fires each due event, re-queues each periodic one as
//   above, ends the walk on an empty queue, the firing cap or a head not yet due,
//   and then hands over the final result.
// Reset: synchronous; the queue comes up empty at time zero. Slot memory is
//   not cleared: only occupied slots are ever read.
// Stalls: req is stalled while an item is in progress; a held rsp transfer
//   stalls the sequencer only when it has a new result to hand over.

module timed_event_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_func,
   input  wire logic [31:0]                   req_time_value,
   input  wire logic [15:0]                   req_event_tag,
   input  wire logic                          req_reload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_result_kind,
   output logic [15:0]                        rsp_fired_tag,
   output logic [31:0]                        rsp_fire_time,
   output logic                               rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,       // waiting for a request
      ST_HEAD,       // tick: read the head slot or stop
      ST_CHECK,      // tick: head data back, fire or stop
      ST_INS_START,  // insert: read the tail neighbor
      ST_SCAN,       // insert: move larger-or-equal entries up one slot
      ST_PLACE,      // insert: write the new entry
      ST_DONE        // hand over the final result of the item
   } state_type;

   localparam int TIME_W = teq_pkg::TIME_W;
   localparam int IDX_W  = teq_pkg::IDX_W;
   localparam int CNT_W  = teq_pkg::CNT_W;
   localparam int FIRE_W = teq_pkg::FIRE_W;

   // ---------------------------------------------------------------------
   // Slot memory: circular, logical position 0 sits at head_ff.
   // ---------------------------------------------------------------------
   teq_pkg::slot_type slot_mem [teq_pkg::QUEUE_DEPTH];
   teq_pkg::slot_type rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   teq_pkg::slot_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   state_type                     state_ff, state_in;
   logic [TIME_W-1:0]             now_ff, now_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;      // insertion hole, logical
   logic [FIRE_W-1:0]             fires_ff, fires_in;
   logic                          in_tick_ff, in_tick_in;
   logic                          pend_ff, pend_in;    // fired result held back for last
   logic [teq_pkg::TAG_BITS-1:0]  pend_tag_ff, pend_tag_in;
   teq_pkg::kind_type             done_kind_ff, done_kind_in;
   teq_pkg::slot_type             ins_ff, ins_in;      // entry being inserted

   logic              rsp_load;
   teq_pkg::rsp_type  rsp_data;
   logic              out_free;

   logic              req_take;
   logic              head_due;
   logic [IDX_W-1:0]  pos_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign head_due  = (rd_data_ff.due <= now_ff);
   assign pos_dec   = pos_ff - IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      fires_in     = fires_ff;
      in_tick_in   = in_tick_ff;
      pend_in      = pend_ff;
      pend_tag_in  = pend_tag_ff;
      done_kind_in = done_kind_ff;
      ins_in       = ins_ff;

      rd_en   = 1'b0;
      rd_addr = head_ff;
      wr_en   = 1'b0;
      wr_addr = teq_pkg::slot_addr(head_ff, pos_ff);
      wr_data = ins_ff;

      rsp_load           = 1'b0;
      rsp_data.kind      = teq_pkg::KIND_FIRED;
      rsp_data.tag       = teq_pkg::tag_to_port(pend_tag_ff);
      rsp_data.fire_time = now_ff;
      rsp_data.last      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  teq_pkg::FUNC_TICK: begin
                     now_in     = req_time_value;
                     fires_in   = '0;
                     pend_in    = 1'b0;
                     in_tick_in = 1'b1;
                     state_in   = ST_HEAD;
                  end
                  teq_pkg::FUNC_ABS, teq_pkg::FUNC_REL: begin
                     in_tick_in = 1'b0;
                     if (cnt_ff == CNT_W'(teq_pkg::QUEUE_DEPTH)) begin
                        done_kind_in = teq_pkg::KIND_REJECTED;
                        state_in     = ST_DONE;
                     end else begin
                        ins_in.tag = teq_pkg::tag_from_port(req_event_tag);
                        if (req_func == teq_pkg::FUNC_ABS) begin
                           ins_in.due    = req_time_value;
                           ins_in.period = '0;
                        end else begin
                           ins_in.due    = teq_pkg::sat_add(now_ff, req_time_value);
                           ins_in.period = req_reload ? req_time_value : '0;
                        end
                        pos_in       = cnt_ff[IDX_W-1:0];
                        done_kind_in = teq_pkg::KIND_ACCEPTED;
                        state_in     = ST_INS_START;
                     end
                  end
                  default: begin
                     // unused code: no effect, no result
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_HEAD: begin
            if ((cnt_ff == '0) || (fires_ff == FIRE_W'(teq_pkg::MAX_FIRES))) begin
               done_kind_in = pend_ff ? teq_pkg::KIND_FIRED : teq_pkg::KIND_NONE_DUE;
               state_in     = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (!head_due) begin
               done_kind_in = pend_ff ? teq_pkg::KIND_FIRED : teq_pkg::KIND_NONE_DUE;
               state_in     = ST_DONE;
            end else if (!pend_ff || out_free) begin
               // previous fired event now known not to be the last one
               rsp_load    = pend_ff;
               pend_in     = 1'b1;
               pend_tag_in = rd_data_ff.tag;
               fires_in    = fires_ff + FIRE_W'(1);
               head_in     = teq_pkg::slot_addr(head_ff, IDX_W'(1));
               cnt_in      = cnt_ff - CNT_W'(1);
               if (rd_data_ff.period != '0) begin
                  ins_in.due    = teq_pkg::sat_add(now_ff, rd_data_ff.period);
                  ins_in.period = rd_data_ff.period;
                  ins_in.tag    = rd_data_ff.tag;
                  pos_in        = cnt_in[IDX_W-1:0];
                  state_in      = ST_INS_START;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end

         ST_INS_START: begin
            if (pos_ff == '0) begin
               state_in = ST_PLACE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = teq_pkg::slot_addr(head_ff, pos_dec);
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // rd_data_ff holds logical pos_ff-1; new entry goes before equals
            if (rd_data_ff.due >= ins_ff.due) begin
               wr_en   = 1'b1;
               wr_addr = teq_pkg::slot_addr(head_ff, pos_ff);
               wr_data = rd_data_ff;
               pos_in  = pos_dec;
               if (pos_dec == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = teq_pkg::slot_addr(head_ff, pos_dec - IDX_W'(1));
                  state_in = ST_SCAN;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = teq_pkg::slot_addr(head_ff, pos_ff);
            wr_data  = ins_ff;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = in_tick_ff ? ST_HEAD : ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_data.kind = done_kind_ff;
               rsp_data.last = 1'b1;
               case (done_kind_ff)
                  teq_pkg::KIND_FIRED: begin
                     rsp_data.tag       = teq_pkg::tag_to_port(pend_tag_ff);
                     rsp_data.fire_time = now_ff;
                  end
                  teq_pkg::KIND_NONE_DUE: begin
                     rsp_data.tag       = '0;
                     rsp_data.fire_time = now_ff;
                  end
                  default: begin
                     rsp_data.tag       = '0;
                     rsp_data.fire_time = '0;
                  end
               endcase
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         now_ff     <= '0;
         cnt_ff     <= '0;
         head_ff    <= '0;
         fires_ff   <= '0;
         in_tick_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         now_ff     <= now_in;
         cnt_ff     <= cnt_in;
         head_ff    <= head_in;
         fires_ff   <= fires_in;
         in_tick_ff <= in_tick_in;
         pend_ff    <= pend_in;
      end
      pos_ff       <= pos_in;
      pend_tag_ff  <= pend_tag_in;
      done_kind_ff <= done_kind_in;
      ins_ff       <= ins_in;
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   teq_rsp_reg u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (rsp_load),
      .load_data       (rsp_data),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_fired_tag   (rsp_fired_tag),
      .rsp_fire_time   (rsp_fire_time),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== design/teq_rsp_reg.sv =====
// Result output register with valid/stall handshake.
// Depends on teq_pkg (rsp_type).
`default_nettype none

module teq_rsp_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire teq_pkg::rsp_type                  load_data,
   output logic                                   free,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_result_kind,
   output logic [teq_pkg::PORT_TAG_W-1:0]         rsp_fired_tag,
   output logic [teq_pkg::TIME_W-1:0]             rsp_fire_time,
   output logic                                   rsp_last
);

   logic             valid_ff;
   logic             valid_in;
   teq_pkg::rsp_type data_ff;

   // slot frees up in the same cycle its transfer completes
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = data_ff.kind;
   assign rsp_fired_tag   = data_ff.tag;
   assign rsp_fire_time   = data_ff.fire_time;
   assign rsp_last        = data_ff.last;

endmodule

`default_nettype wire
